// ----- hw/rtl/track_offset_smoother_exit_latch_top_defines.svh -----
// assertion helpers shared by the rtl, clocked on aclk and gated by reset
`ifndef TRACK_OFFSET_SMOOTHER_EXIT_LATCH_TOP_DEFINES_SVH
`define TRACK_OFFSET_SMOOTHER_EXIT_LATCH_TOP_DEFINES_SVH

// same-cycle implication
`define TOSEL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TOSEL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/tosel_pkg.sv -----
package tosel_pkg;

    localparam int ARM_FRAMES_DEF = 5;

    // stream widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    // field widths
    localparam int TGT_W   = 14;
    localparam int CONF_W  = 7;
    localparam int STATE_W = 16;
    localparam int STEER_W = 7;
    localparam int CR_W    = 3;
    localparam int MR_W    = 4;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // serial multiplier
    localparam int MCAND_W  = 17;
    localparam int MPLIER_W = 9;
    localparam int PROD_W   = 27;
    localparam int MCNT_W   = $clog2(MPLIER_W);

    localparam logic signed [MCAND_W-1:0] TGT_STEP = 17'sd819;
    localparam logic signed [MCAND_W-1:0] OFS_STEP = 17'sd5120;
    localparam logic [MPLIER_W-1:0] TGT_W_BOTH = 9'd218;
    localparam logic [MPLIER_W-1:0] TGT_W_ONE  = 9'd192;
    localparam logic [CONF_W-1:0] ARM_CONF   = 7'd55;
    localparam logic [CONF_W-1:0] CONF_DECAY = 7'd25;
    localparam logic [CONF_W-1:0] CONF_MAX   = 7'd100;

    localparam logic [8:0] ALPHA_MIN = 9'd13;
    localparam logic [8:0] ALPHA_MAX = 9'd256;
    localparam logic [8:0] GAIN_MIN  = 9'd100;
    localparam logic [8:0] GAIN_MAX  = 9'd350;
    localparam logic [5:0] CLAMP_MIN = 6'd20;
    localparam logic [5:0] CLAMP_MAX = 6'd45;

    localparam logic [8:0] ALPHA_RST = 9'd205;
    localparam logic [3:0] NEED_RST  = 4'd3;
    localparam logic [8:0] GAIN_RST  = 9'd230;
    localparam logic [5:0] CLAMP_RST = 6'd40;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA   = 2'd0,
        CFG_MISSING = 2'd1,
        CFG_GAIN    = 2'd2,
        CFG_CLAMP   = 2'd3
    } cfg_idx_t;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_TMUL = 8'b0000_0010,
        S_TADD = 8'b0000_0100,
        S_GMUL = 8'b0000_1000,
        S_GADD = 8'b0001_0000,
        S_OMUL = 8'b0010_0000,
        S_OADD = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    // arithmetic shift right, rounding half away from zero
    function automatic logic signed [PROD_W-1:0] rnd_shr(
        input logic signed [PROD_W-1:0] v,
        input logic [3:0] sh
    );
        logic signed [PROD_W-1:0] half;
        logic signed [PROD_W-1:0] mag;
        half = $signed({{(PROD_W-1){1'b0}}, 1'b1} << (sh - 4'd1));
        mag = -v;
        if (v >= 0) begin
            rnd_shr = (v + half) >>> sh;
        end else begin
            rnd_shr = -((mag + half) >>> sh);
        end
    endfunction

endpackage

// ----- hw/rtl/tosel_mul.sv -----
module tosel_mul (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic signed [tosel_pkg::MCAND_W-1:0]   mcand,
    input  logic        [tosel_pkg::MPLIER_W-1:0]  mplier,
    output logic signed [tosel_pkg::PROD_W-1:0]    product,
    output tosel_pkg::mul_stat_t                   stat
);
    import tosel_pkg::*;

    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [PROD_W-1:0] mc_reg, mc_next;
    logic [MPLIER_W-1:0]      mp_reg, mp_next;
    logic [MCNT_W-1:0]        cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;

    // one multiplier bit per cycle, lsb first
    always_comb begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next  = '0;
            mc_next   = PROD_W'(mcand);
            mp_next   = mplier;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (mp_reg[0]) begin
                acc_next = acc_reg + mc_reg;
            end
            mc_next  = mc_reg <<< 1;
            mp_next  = mp_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MCNT_W'(MPLIER_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign product   = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- hw/rtl/track_offset_smoother_exit_latch_top.sv -----
// Path-offset smoother with section-exit latch, one transaction per scan frame.
// s_ channel: one path estimate per frame, accepted when s_tvalid and s_tready.
// m_ channel: exactly one result per accepted frame, in order.
// cfg_we/cfg_index/cfg_wdata: register writes, taken on any edge with cfg_we high;
// write only while no frame is in flight.
// A found frame runs three shift-add multiplies on one shared serial multiplier
// (target weight, steering gain, offset weight) before its result is loaded.
// The first found frame seeds both filters and skips two multiplies. Missing
// frames and frames after the end latch go straight to the output state.
// s_tready returns as the result is loaded into the output register, so one
// found frame is through before the next frame is accepted.
// The result sits in an output register; a new frame is accepted while it waits.
// If the receiver stalls and a second result is ready, the block holds in its
// output state until the register frees up.
// Reset (aresetn low, synchronous) restores register defaults and clears all
// filter, counter and latch state; the output channel goes empty.
`include "track_offset_smoother_exit_latch_top_defines.svh"

module track_offset_smoother_exit_latch_top #(
    parameter int ARM_FRAMES = tosel_pkg::ARM_FRAMES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [tosel_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tosel_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // lateral_target [13:0], confidence_in [20:14], zero pad
    input  logic [tosel_pkg::S_TDATA_W-1:0]      s_tdata,
    // path_found [0], both_sides [1]
    input  logic [tosel_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // steer_offset [6:0], section_end [7], confidence_out [14:8], zero pad
    output logic [tosel_pkg::M_TDATA_W-1:0]      m_tdata
);
    import tosel_pkg::*;

    // configuration
    logic [8:0] alpha_reg;
    logic [3:0] need_reg;
    logic [8:0] gain_reg;
    logic [5:0] clamp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= ALPHA_RST;
            need_reg  <= NEED_RST;
            gain_reg  <= GAIN_RST;
            clamp_reg <= CLAMP_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ALPHA:   alpha_reg <= cfg_wdata;
                CFG_MISSING: need_reg  <= cfg_wdata[3:0];
                CFG_GAIN:    gain_reg  <= cfg_wdata;
                CFG_CLAMP:   clamp_reg <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    logic [8:0]               alpha_eff;
    logic [3:0]               need_eff;
    logic [8:0]               gain_eff;
    logic [5:0]               clamp_eff;
    logic signed [PROD_W-1:0] lim;

    assign alpha_eff = (alpha_reg < ALPHA_MIN) ? ALPHA_MIN :
                       (alpha_reg > ALPHA_MAX) ? ALPHA_MAX : alpha_reg;
    assign need_eff  = (need_reg == 4'd0) ? 4'd1 : need_reg;
    assign gain_eff  = (gain_reg < GAIN_MIN) ? GAIN_MIN :
                       (gain_reg > GAIN_MAX) ? GAIN_MAX : gain_reg;
    assign clamp_eff = (clamp_reg < CLAMP_MIN) ? CLAMP_MIN :
                       (clamp_reg > CLAMP_MAX) ? CLAMP_MAX : clamp_reg;
    assign lim       = $signed({{(PROD_W-14){1'b0}}, clamp_eff, 8'd0});

    // input decode
    logic                     in_found;
    logic                     in_both;
    logic signed [TGT_W-1:0]  in_tgt;
    logic [CONF_W-1:0]        in_conf_raw;
    logic [CONF_W-1:0]        in_conf;

    assign in_found    = s_tuser[0];
    assign in_both     = s_tuser[1];
    assign in_tgt      = $signed(s_tdata[TGT_W-1:0]);
    assign in_conf_raw = s_tdata[TGT_W+CONF_W-1:TGT_W];
    assign in_conf     = (in_conf_raw > CONF_MAX) ? CONF_MAX : in_conf_raw;

    // state
    state_t                    state_reg, state_next;
    logic                      start_reg, start_next;
    logic                      both_reg, both_next;
    logic signed [TGT_W-1:0]   tgt_reg, tgt_next;
    logic signed [STATE_W-1:0] st_reg, st_next;
    logic                      t_seed_reg, t_seed_next;
    logic signed [STATE_W-1:0] so_reg, so_next;
    logic                      o_seed_reg, o_seed_next;
    logic signed [STATE_W-1:0] raw_reg, raw_next;
    logic [CR_W-1:0]           cr_reg, cr_next;
    logic [MR_W-1:0]           mr_reg, mr_next;
    logic                      armed_reg, armed_next;
    logic                      end_latched_reg, end_latched_next;
    logic [CONF_W-1:0]         held_conf_reg, held_conf_next;
    logic                      end_out_reg, end_out_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]      m_tdata_reg, m_tdata_next;

    // shared serial multiplier
    logic signed [MCAND_W-1:0] mul_mcand;
    logic [MPLIER_W-1:0]       mul_mplier;
    logic signed [PROD_W-1:0]  mul_prod;
    mul_stat_t                 mul_stat;

    tosel_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .product (mul_prod),
        .stat    (mul_stat)
    );

    // operand selection
    logic signed [MCAND_W-1:0] dt_full, dt, do_full, dof, neg_st;
    logic [MPLIER_W-1:0]       tw, ow;

    assign dt_full = MCAND_W'(tgt_reg) - MCAND_W'(st_reg);
    assign dt      = (dt_full > TGT_STEP) ? TGT_STEP :
                     (dt_full < -TGT_STEP) ? -TGT_STEP : dt_full;
    assign do_full = MCAND_W'(raw_reg) - MCAND_W'(so_reg);
    assign dof     = (do_full > OFS_STEP) ? OFS_STEP :
                     (do_full < -OFS_STEP) ? -OFS_STEP : do_full;
    assign neg_st  = -MCAND_W'(st_reg);
    assign tw      = both_reg ? TGT_W_BOTH : TGT_W_ONE;
    assign ow      = both_reg ? alpha_eff :
                     ((alpha_eff < TGT_W_ONE) ? alpha_eff : TGT_W_ONE);

    always_comb begin
        unique case (state_reg)
            S_TMUL: begin
                mul_mcand  = dt;
                mul_mplier = tw;
            end
            S_GMUL: begin
                mul_mcand  = neg_st;
                mul_mplier = gain_eff;
            end
            S_OMUL: begin
                mul_mcand  = dof;
                mul_mplier = ow;
            end
            default: begin
                mul_mcand  = '0;
                mul_mplier = '0;
            end
        endcase
    end

    // product rounding
    logic signed [PROD_W-1:0]  prod_rnd8, prod_rnd4, so_rnd;
    logic signed [STATE_W-1:0] raw_cl;

    assign prod_rnd8 = rnd_shr(mul_prod, 4'd8);
    assign prod_rnd4 = rnd_shr(mul_prod, 4'd4);
    assign raw_cl    = (prod_rnd4 > lim)  ? STATE_W'(lim)  :
                       (prod_rnd4 < -lim) ? STATE_W'(-lim) : STATE_W'(prod_rnd4);
    assign so_rnd    = rnd_shr(PROD_W'(so_reg), 4'd8);

    // run counters, saturating
    logic [CR_W-1:0] cr_upd;
    logic [MR_W-1:0] mr_upd;

    assign cr_upd = (in_conf < ARM_CONF) ? '0 :
                    (&cr_reg) ? cr_reg : cr_reg + 1'b1;
    assign mr_upd = (&mr_reg) ? mr_reg : mr_reg + 1'b1;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next       = state_reg;
        start_next       = 1'b0;
        both_next        = both_reg;
        tgt_next         = tgt_reg;
        st_next          = st_reg;
        t_seed_next      = t_seed_reg;
        so_next          = so_reg;
        o_seed_next      = o_seed_reg;
        raw_next         = raw_reg;
        cr_next          = cr_reg;
        mr_next          = mr_reg;
        armed_next       = armed_reg;
        end_latched_next = end_latched_reg;
        held_conf_next   = held_conf_reg;
        end_out_next     = end_out_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    both_next = in_both;
                    tgt_next  = in_tgt;
                    if (end_latched_reg) begin
                        held_conf_next = '0;
                        end_out_next   = 1'b1;
                        state_next     = S_OUT;
                    end else if (in_found) begin
                        mr_next        = '0;
                        end_out_next   = 1'b0;
                        held_conf_next = in_conf;
                        if (!armed_reg) begin
                            cr_next = cr_upd;
                            if (cr_upd >= CR_W'(ARM_FRAMES)) begin
                                armed_next = 1'b1;
                            end
                        end
                        if (t_seed_reg) begin
                            state_next = S_TMUL;
                            start_next = 1'b1;
                        end else begin
                            state_next = S_TADD;
                        end
                    end else begin
                        end_out_next   = 1'b0;
                        held_conf_next = (held_conf_reg > CONF_DECAY) ?
                                         held_conf_reg - CONF_DECAY : '0;
                        if (!armed_reg) begin
                            cr_next = '0;
                        end else begin
                            mr_next = mr_upd;
                            if (mr_upd >= need_eff) begin
                                end_latched_next = 1'b1;
                                end_out_next     = 1'b1;
                                held_conf_next   = '0;
                            end
                        end
                        state_next = S_OUT;
                    end
                end
            end
            S_TMUL: begin
                if (mul_stat.done) begin
                    state_next = S_TADD;
                end
            end
            S_TADD: begin
                if (t_seed_reg) begin
                    st_next = st_reg + STATE_W'(prod_rnd8);
                end else begin
                    st_next     = STATE_W'(tgt_reg);
                    t_seed_next = 1'b1;
                end
                state_next = S_GMUL;
                start_next = 1'b1;
            end
            S_GMUL: begin
                if (mul_stat.done) begin
                    state_next = S_GADD;
                end
            end
            S_GADD: begin
                if (o_seed_reg) begin
                    raw_next   = raw_cl;
                    state_next = S_OMUL;
                    start_next = 1'b1;
                end else begin
                    so_next     = raw_cl;
                    o_seed_next = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_OMUL: begin
                if (mul_stat.done) begin
                    state_next = S_OADD;
                end
            end
            S_OADD: begin
                so_next    = so_reg + STATE_W'(prod_rnd8);
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, held_conf_reg, end_out_reg,
                                     so_rnd[STEER_W-1:0]};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        both_reg    <= both_next;
        tgt_reg     <= tgt_next;
        raw_reg     <= raw_next;
        m_tdata_reg <= m_tdata_next;
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            start_reg       <= 1'b0;
            st_reg          <= '0;
            t_seed_reg      <= 1'b0;
            so_reg          <= '0;
            o_seed_reg      <= 1'b0;
            cr_reg          <= '0;
            mr_reg          <= '0;
            armed_reg       <= 1'b0;
            end_latched_reg <= 1'b0;
            held_conf_reg   <= '0;
            end_out_reg     <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            start_reg       <= start_next;
            st_reg          <= st_next;
            t_seed_reg      <= t_seed_next;
            so_reg          <= so_next;
            o_seed_reg      <= o_seed_next;
            cr_reg          <= cr_next;
            mr_reg          <= mr_next;
            armed_reg       <= armed_next;
            end_latched_reg <= end_latched_next;
            held_conf_reg   <= held_conf_next;
            end_out_reg     <= end_out_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // the multiplier is idle whenever a new transaction can enter
    `TOSEL_ASSERT_NOW(a_idle_mul_free, s_tready, !mul_stat.busy, "multiplier busy while idle")
    // a product only completes while the sequencer waits for it
    `TOSEL_ASSERT_NOW(a_done_in_wait, mul_stat.done,
        (state_reg == S_TMUL) || (state_reg == S_GMUL) || (state_reg == S_OMUL),
        "multiplier done outside a wait state")
    // missing frames are only counted once exit detection is armed
    `TOSEL_ASSERT_NOW(a_missing_armed, mr_reg != '0, armed_reg, "missing run while not armed")
    // the section end never unlatches
    `TOSEL_ASSERT_NEXT(a_end_sticky, end_latched_reg, end_latched_reg, "section end released")

endmodule
